// ----- rtl/escape_time_fractal_engine_assert.svh -----
// Assertion helpers used by etfe_back.
// Each expects signals named clock and reset in the using module.
`ifndef ESCAPE_TIME_FRACTAL_ENGINE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ENGINE_ASSERT_SVH

// same-cycle implication
`define ETFE_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("etfe assertion failed");

// next-cycle implication
`define ETFE_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("etfe assertion failed");

`endif

// ----- rtl/etfe_pkg.sv -----
package etfe_pkg;

   // default geometry
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int ITER_BITS_DEF  = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // register file
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_JULIA_MODE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_ITERATIONS = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_JULIA_CONST_RE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_JULIA_CONST_IM = 2'd3;

   // reset values; Julia constant given in Q.28 and rescaled per FRAC_BITS
   localparam int RESET_FRAC = 28;
   localparam logic signed [63:0] JULIA_RE_Q28 = -64'sd137573171;
   localparam logic signed [63:0] JULIA_IM_Q28 = 64'sd139935403;
   localparam int MAX_ITER_RESET = 256;

   // escape thresholds, integer parts
   localparam int ESCAPE_INT = 7;
   localparam int SURE_INT   = 3;

endpackage

// ----- rtl/escape_time_fractal_engine.sv -----
// Escape-time fractal engine: one complex point in, one iteration count out.
// req_*: stream of points (point_re low half, point_im high half of tdata).
// rsp_*: stream of results; tdata carries iteration_count, tuser inside_set.
// csr_*: register writes (julia_mode, max_iterations, julia_const_re/_im);
//        always ready; write only while the engine is idle (unchecked).
// The front classifies each point (selects starting z and c by mode, snaps
// the limit) and drops it into a two-entry queue; the back iterates.
// Each back iteration runs a multiply state, then an add-and-test state,
// split by the registered square/cross products feeding the update.
// Points are worked one at a time.
// The result sits in an output register; while the receiver stalls, the back
// finishes its current point and the queue accepts points until it is full.
// Reset (synchronous, active high) empties queue and output, and restores
// the registers: Mandelbrot mode, limit 256, default Julia constant.
module escape_time_fractal_engine #(
   parameter int COORD_BITS = etfe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = etfe_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS  = etfe_pkg::ITER_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // point_re, point_im (from bit 0 up)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]   req_tdata,
   // iteration_count
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((ITER_BITS+7)/8)*8-1:0]      rsp_tdata,
   // inside_set
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [etfe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((COORD_BITS > ITER_BITS) ? COORD_BITS : ITER_BITS)-1:0] csr_data
);

   localparam int CSR_BITS = (COORD_BITS > ITER_BITS) ? COORD_BITS : ITER_BITS;
   localparam int JOB_BITS = 4 * COORD_BITS + ITER_BITS;
   localparam int RSP_BITS = ((ITER_BITS + 7) / 8) * 8;

   logic                  fq_valid, fq_ready;
   logic [JOB_BITS-1:0]   fq_data;
   logic                  qb_valid, qb_ready;
   logic [JOB_BITS-1:0]   qb_data;
   logic [ITER_BITS-1:0]  rsp_count;

   etfe_front #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_BITS  (ITER_BITS),
      .CSR_BITS   (CSR_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .pt_valid  (req_tvalid),
      .pt_ready  (req_tready),
      .point_re  (req_tdata[COORD_BITS-1:0]),
      .point_im  (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_valid (fq_valid),
      .job_ready (fq_ready),
      .job_data  (fq_data)
   );

   // decouples classification from iteration
   etfe_queue #(
      .WIDTH (JOB_BITS),
      .DEPTH (etfe_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   etfe_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .ITER_BITS  (ITER_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qb_valid),
      .job_ready  (qb_ready),
      .job_data   (qb_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_count  (rsp_count),
      .rsp_inside (rsp_tuser)
   );

   // count zero-filled up to whole bytes
   assign rsp_tdata = RSP_BITS'(rsp_count);

endmodule

// ----- rtl/etfe_queue.sv -----
module etfe_queue #(
   parameter int WIDTH = 144,
   parameter int DEPTH = etfe_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/etfe_front.sv -----
module etfe_front #(
   parameter int COORD_BITS = etfe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = etfe_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS  = etfe_pkg::ITER_BITS_DEF,
   parameter int CSR_BITS   = etfe_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // point in
   input  logic                                pt_valid,
   output logic                                pt_ready,
   input  logic signed [COORD_BITS-1:0]        point_re,
   input  logic signed [COORD_BITS-1:0]        point_im,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [etfe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]                 csr_data,
   // job out: {lim, ci, cr, zi0, zr0}
   output logic                                job_valid,
   input  logic                                job_ready,
   output logic [4*COORD_BITS+ITER_BITS-1:0]   job_data
);

   localparam int UP_SH = (FRAC_BITS >= etfe_pkg::RESET_FRAC) ?
                          FRAC_BITS - etfe_pkg::RESET_FRAC : 0;
   localparam int DN_SH = (FRAC_BITS >= etfe_pkg::RESET_FRAC) ?
                          0 : etfe_pkg::RESET_FRAC - FRAC_BITS;
   localparam logic signed [63:0] JRE64 = (etfe_pkg::JULIA_RE_Q28 <<< UP_SH) >>> DN_SH;
   localparam logic signed [63:0] JIM64 = (etfe_pkg::JULIA_IM_Q28 <<< UP_SH) >>> DN_SH;
   localparam logic signed [COORD_BITS-1:0] JRE_RST = COORD_BITS'(JRE64);
   localparam logic signed [COORD_BITS-1:0] JIM_RST = COORD_BITS'(JIM64);
   localparam logic [ITER_BITS-1:0] MAXI_RST =
      ITER_BITS'((ITER_BITS > 8) ? etfe_pkg::MAX_ITER_RESET : (2 ** ITER_BITS - 1));

   logic                         julia_mode_ff;
   logic [ITER_BITS-1:0]         max_iter_ff;
   logic signed [COORD_BITS-1:0] jc_re_ff;
   logic signed [COORD_BITS-1:0] jc_im_ff;
   logic                         csr_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         julia_mode_ff <= 1'b0;
         max_iter_ff   <= MAXI_RST;
         jc_re_ff      <= JRE_RST;
         jc_im_ff      <= JIM_RST;
      end else if (csr_wr) begin
         case (csr_index)
            etfe_pkg::REG_JULIA_MODE:     julia_mode_ff <= csr_data[0];
            etfe_pkg::REG_MAX_ITERATIONS: max_iter_ff   <= csr_data[ITER_BITS-1:0];
            etfe_pkg::REG_JULIA_CONST_RE: jc_re_ff      <= csr_data[COORD_BITS-1:0];
            etfe_pkg::REG_JULIA_CONST_IM: jc_im_ff      <= csr_data[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // classify: pick starting z and c by mode, snapshot the limit
   assign pt_ready  = job_ready;
   assign job_valid = pt_valid;

   always_comb begin
      if (julia_mode_ff) begin
         job_data = {max_iter_ff, jc_im_ff, jc_re_ff, point_im, point_re};
      end else begin
         job_data = {max_iter_ff, point_im, point_re,
                     {COORD_BITS{1'b0}}, {COORD_BITS{1'b0}}};
      end
   end

endmodule

// ----- rtl/etfe_back.sv -----
module etfe_back #(
   parameter int COORD_BITS = etfe_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = etfe_pkg::FRAC_BITS_DEF,
   parameter int ITER_BITS  = etfe_pkg::ITER_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_valid,
   output logic                              job_ready,
   input  logic [4*COORD_BITS+ITER_BITS-1:0] job_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ITER_BITS-1:0]              rsp_count,
   output logic                              rsp_inside
);

`include "escape_time_fractal_engine_assert.svh"

   localparam int CB = COORD_BITS;
   localparam int PW = 2 * COORD_BITS;       // product width
   localparam int W  = 2 * COORD_BITS + 2;   // update sum width

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;
   localparam logic [1:0] ST_HOLD = 2'd3;

   localparam logic signed [W-1:0]  SURE_W   = W'(etfe_pkg::SURE_INT) <<< FRAC_BITS;
   localparam logic signed [W-1:0]  NSURE_W  = -SURE_W;
   localparam logic signed [CB-1:0] SURE_C   = CB'(etfe_pkg::SURE_INT) <<< FRAC_BITS;
   localparam logic signed [CB-1:0] NSURE_C  = -SURE_C;
   localparam logic [PW:0]          ESC_LIM  = (PW+1)'(etfe_pkg::ESCAPE_INT) << (2 * FRAC_BITS);

   logic [1:0]           state_ff, state_in;
   logic signed [CB-1:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [CB-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic [ITER_BITS-1:0] lim_ff, lim_in;
   logic [ITER_BITS-1:0] iter_ff, iter_in;
   logic                 chk_ff, chk_in;
   logic signed [PW-1:0] prr_ff, pii_ff, pri_ff;
   logic [ITER_BITS-1:0] res_cnt_ff, res_cnt_in;
   logic                 res_ins_ff, res_ins_in;
   logic                 out_vld_ff, out_vld_in;
   logic [ITER_BITS-1:0] out_cnt_ff;
   logic                 out_ins_ff;

   logic signed [W-1:0]  sum_re, sum_im, nr_full, ni_full;
   logic [PW:0]          mag_sq;
   logic                 escaped, sure, last, out_free, load_out;
   logic [ITER_BITS-1:0] idx;

   // one step of z*z + c from the registered products, floor to Q.FRAC
   assign sum_re  = W'(prr_ff) - W'(pii_ff) + (W'(cr_ff) <<< FRAC_BITS);
   assign sum_im  = W'(pri_ff) + (W'(ci_ff) <<< (FRAC_BITS - 1));
   assign nr_full = sum_re >>> FRAC_BITS;
   assign ni_full = sum_im >>> (FRAC_BITS - 1);
   assign sure    = (nr_full >= SURE_W) || (nr_full <= NSURE_W) ||
                    (ni_full >= SURE_W) || (ni_full <= NSURE_W);

   // squares of the current z double as the escape test of the previous step
   assign mag_sq  = {1'b0, prr_ff} + {1'b0, pii_ff};
   assign escaped = mag_sq > ESC_LIM;
   assign last    = ({1'b0, iter_ff} + 1'b1) == {1'b0, lim_ff};
   assign idx     = chk_ff ? iter_ff + 1'b1 : '0;

   assign out_free  = !out_vld_ff || rsp_ready;
   assign load_out  = (state_ff == ST_HOLD) && out_free;
   assign job_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      zr_in      = zr_ff;
      zi_in      = zi_ff;
      cr_in      = cr_ff;
      ci_in      = ci_ff;
      lim_in     = lim_ff;
      iter_in    = iter_ff;
      chk_in     = chk_ff;
      res_cnt_in = res_cnt_ff;
      res_ins_in = res_ins_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               zr_in   = job_data[CB-1:0];
               zi_in   = job_data[2*CB-1:CB];
               cr_in   = job_data[3*CB-1:2*CB];
               ci_in   = job_data[4*CB-1:3*CB];
               lim_in  = job_data[4*CB+ITER_BITS-1:4*CB];
               iter_in = '0;
               chk_in  = 1'b0;
               if (job_data[4*CB+ITER_BITS-1:4*CB] == '0) begin
                  res_cnt_in = '0;
                  res_ins_in = 1'b1;
                  state_in   = ST_HOLD;
               end else begin
                  state_in   = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (chk_ff && escaped) begin
               res_cnt_in = iter_ff;
               res_ins_in = 1'b0;
               state_in   = ST_HOLD;
            end else if (chk_ff && last) begin
               res_cnt_in = lim_ff;
               res_ins_in = 1'b1;
               state_in   = ST_HOLD;
            end else begin
               iter_in = idx;
               if (sure) begin
                  res_cnt_in = idx;
                  res_ins_in = 1'b0;
                  state_in   = ST_HOLD;
               end else begin
                  zr_in    = nr_full[CB-1:0];
                  zi_in    = ni_full[CB-1:0];
                  chk_in   = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_vld_in = load_out || (out_vld_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         out_vld_ff <= 1'b0;
         chk_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         chk_ff     <= chk_in;
      end
   end

   always_ff @(posedge clock) begin
      zr_ff      <= zr_in;
      zi_ff      <= zi_in;
      cr_ff      <= cr_in;
      ci_ff      <= ci_in;
      lim_ff     <= lim_in;
      iter_ff    <= iter_in;
      res_cnt_ff <= res_cnt_in;
      res_ins_ff <= res_ins_in;
      if (state_ff == ST_MUL) begin
         prr_ff <= PW'(zr_ff) * PW'(zr_ff);
         pii_ff <= PW'(zi_ff) * PW'(zi_ff);
         pri_ff <= PW'(zr_ff) * PW'(zi_ff);
      end
      if (load_out) begin
         out_cnt_ff <= res_cnt_ff;
         out_ins_ff <= res_ins_ff;
      end
   end

   assign rsp_valid  = out_vld_ff;
   assign rsp_count  = out_cnt_ff;
   assign rsp_inside = out_ins_ff;

   `ETFE_ASSERT_IMP(a_add_follows_mul, state_ff == ST_ADD, $past(state_ff) == ST_MUL)
   `ETFE_ASSERT_IMP(a_iter_below_lim, (state_ff == ST_MUL || state_ff == ST_ADD) && chk_ff, iter_ff < lim_ff)
   `ETFE_ASSERT_IMP(a_z_in_range, state_ff == ST_MUL && chk_ff, zr_ff < SURE_C && zr_ff > NSURE_C && zi_ff < SURE_C && zi_ff > NSURE_C)
   `ETFE_ASSERT_NXT(a_hold_drains, state_ff == ST_HOLD && out_free, rsp_valid)

endmodule
